[rtl/iat_pkg.sv]
// Shared token kinds, scanner modes, character codes and decode functions.
`default_nettype none
package iat_pkg;

   localparam logic [4:0] K_EOF      = 5'd0;
   localparam logic [4:0] K_NEWLINE  = 5'd1;
   localparam logic [4:0] K_INDENT   = 5'd2;
   localparam logic [4:0] K_DEDENT   = 5'd3;
   localparam logic [4:0] K_INT      = 5'd4;
   localparam logic [4:0] K_IDENT    = 5'd5;
   localparam logic [4:0] K_STRING   = 5'd6;
   localparam logic [4:0] K_IF       = 5'd7;
   localparam logic [4:0] K_PLUS     = 5'd13;
   localparam logic [4:0] K_MINUS    = 5'd14;
   localparam logic [4:0] K_STAR     = 5'd15;
   localparam logic [4:0] K_SLASH    = 5'd16;
   localparam logic [4:0] K_LPAREN   = 5'd17;
   localparam logic [4:0] K_RPAREN   = 5'd18;
   localparam logic [4:0] K_LBRACKET = 5'd19;
   localparam logic [4:0] K_RBRACKET = 5'd20;
   localparam logic [4:0] K_COMMA    = 5'd21;
   localparam logic [4:0] K_EQUALS   = 5'd22;
   localparam logic [4:0] K_EQ       = 5'd23;
   localparam logic [4:0] K_COLON    = 5'd24;
   localparam logic [4:0] K_NE       = 5'd25;
   localparam logic [4:0] K_LT       = 5'd26;
   localparam logic [4:0] K_LE       = 5'd27;
   localparam logic [4:0] K_GT       = 5'd28;
   localparam logic [4:0] K_GE       = 5'd29;
   localparam logic [4:0] K_ERROR    = 5'd30;

   localparam logic [2:0] E_NONE       = 3'd0;
   localparam logic [2:0] E_TOO_DEEP   = 3'd1;
   localparam logic [2:0] E_UNINDENT   = 3'd2;
   localparam logic [2:0] E_SYNTAX     = 3'd3;
   localparam logic [2:0] E_UNEXPECTED = 3'd4;
   localparam logic [2:0] E_UNTERM     = 3'd5;

   localparam logic [3:0] M_LINE    = 4'd0;
   localparam logic [3:0] M_NORMAL  = 4'd1;
   localparam logic [3:0] M_COMMENT = 4'd2;
   localparam logic [3:0] M_INT     = 4'd3;
   localparam logic [3:0] M_IDENT   = 4'd4;
   localparam logic [3:0] M_STRING  = 4'd5;
   localparam logic [3:0] M_OPEQ    = 4'd6;
   localparam logic [3:0] M_OPBANG  = 4'd7;
   localparam logic [3:0] M_OPLT    = 4'd8;
   localparam logic [3:0] M_OPGT    = 4'd9;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam int         KW_COUNT  = 6;
   localparam logic [8:0] KW_FRESH  = 9'h03F;

   typedef struct packed {
      logic       emit;
      logic [4:0] kind;
      logic [2:0] err;
      logic [3:0] mode;
      logic       wide;
      logic       nl;
   } start_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) || (c == CH_UNDER);
   endfunction

   function automatic logic [2:0] kw_len(input int k);
      logic [2:0] l;
      case (k)
         0: l = 3'd2;
         1, 2, 3: l = 3'd4;
         default: l = 3'd5;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [2:0] j);
      logic [39:0] w;
      logic [2:0]  l;
      case (k)
         0: w = "if";
         1: w = "elif";
         2: w = "else";
         3: w = "pass";
         4: w = "print";
         default: w = "while";
      endcase
      l = kw_len(k);
      if (j < l) begin
         return w[8 * (32'(l) - 1 - 32'(j)) +: 8];
      end
      return CH_NUL;
   endfunction

   // Narrows the candidate keyword set by one more identifier character.
   function automatic logic [8:0] kw_feed(input logic [8:0] km, input logic [7:0] c);
      logic [5:0] mask;
      logic [2:0] len;
      mask = km[5:0];
      len  = km[8:6];
      if (len < 3'd7) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (mask[k] && !(len < kw_len(k) && kw_char(k, len) == c)) begin
               mask[k] = 1'b0;
            end
         end
         len = len + 3'd1;
      end else begin
         mask = '0;
      end
      return {len, mask};
   endfunction

   function automatic logic [4:0] kw_kind(input logic [8:0] km);
      logic [4:0] kind;
      kind = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (km[k] && kw_len(k) == km[8:6]) begin
            kind = K_IF + 5'(k);
         end
      end
      return kind;
   endfunction

   // What the first byte of a token does.
   function automatic start_type start_decode(input logic [7:0] c, input logic als);
      start_type s;
      s.emit = 1'b0;
      s.kind = K_ERROR;
      s.err  = E_NONE;
      s.mode = M_NORMAL;
      s.wide = 1'b1;
      s.nl   = 1'b0;
      case (c)
         CH_SPACE: s.mode = M_NORMAL;
         CH_HASH:  s.mode = M_COMMENT;
         CH_NUL: begin
            s.emit = 1'b1;
            s.kind = K_EOF;
            s.wide = 1'b0;
         end
         CH_LF: begin
            s.emit = !als;
            s.kind = K_NEWLINE;
            s.mode = M_LINE;
            s.nl   = 1'b1;
         end
         CH_EQ:    s.mode = M_OPEQ;
         CH_BANG:  s.mode = M_OPBANG;
         CH_LT:    s.mode = M_OPLT;
         CH_GT:    s.mode = M_OPGT;
         CH_QUOTE: s.mode = M_STRING;
         CH_PLUS:  begin s.emit = 1'b1; s.kind = K_PLUS;     end
         CH_MINUS: begin s.emit = 1'b1; s.kind = K_MINUS;    end
         CH_STAR:  begin s.emit = 1'b1; s.kind = K_STAR;     end
         CH_SLASH: begin s.emit = 1'b1; s.kind = K_SLASH;    end
         CH_LPAR:  begin s.emit = 1'b1; s.kind = K_LPAREN;   end
         CH_RPAR:  begin s.emit = 1'b1; s.kind = K_RPAREN;   end
         CH_LBRK:  begin s.emit = 1'b1; s.kind = K_LBRACKET; end
         CH_RBRK:  begin s.emit = 1'b1; s.kind = K_RBRACKET; end
         CH_COMMA: begin s.emit = 1'b1; s.kind = K_COMMA;    end
         CH_COLON: begin s.emit = 1'b1; s.kind = K_COLON;    end
         default: begin
            if (is_digit(c)) begin
               s.mode = M_INT;
            end else if (is_alpha(c)) begin
               s.mode = M_IDENT;
            end else begin
               s.emit = 1'b1;
               s.err  = E_UNEXPECTED;
            end
         end
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

[rtl/indentation_aware_tokenizer.sv]
// Top level of the indentation-aware tokenizer.
//
//   Channel  Dir  Transfer carries
//   req_     in   one source byte (0 ends the source)
//   rsp_     out  one token: kind, start, end, error code; tlast on a byte's final token
//
// A byte that ends an integer, a name or a one-character operator, or that opens an
// indentation level, starts its own token afterwards from the held copy in S_START. A
// dedent run pops levels in S_POP, waiting in S_POPW for each read of the indentation
// stack RAM (the pop down to the bottom level needs no read), compares the column with
// the new top, emits one DEDENT token per level popped from S_DED and then starts the
// next token from S_START. Reset is synchronous and needs no clearing pass: the bottom
// stack level is held as the constant zero. A stalled result channel stops the block
// from taking bytes or emitting tokens; no token is lost or repeated. After an error or
// end-of-source token, bytes are still taken but ignored.
`default_nettype none
module indentation_aware_tokenizer #(
   parameter int INDENT_DEPTH = 16,
   parameter int POS_BITS     = 24,
   parameter int COLUMN_BITS  = 12
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata: [7:0] char_in
   input  wire logic [7:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata: kind, start_pos, end_pos, error_code, zero fill
   output logic [((2 * POS_BITS + 8 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic      rsp_tlast
);
   import iat_pkg::*;

   localparam int DATA_BITS  = 2 * POS_BITS + 8;
   localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
   localparam int CNT_W      = $clog2(INDENT_DEPTH + 1);
   localparam int IDX_W      = $clog2(INDENT_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_POP   = 3'd1;
   localparam logic [2:0] S_POPW  = 3'd2;
   localparam logic [2:0] S_DED   = 3'd3;
   localparam logic [2:0] S_START = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [3:0]             mode_ff, mode_in;
   logic                   als_ff, als_in;
   logic                   halted_ff, halted_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [COLUMN_BITS-1:0] top_ff, top_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       ded_ff, ded_in;
   logic [POS_BITS-1:0]    ts_ff, ts_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [POS_BITS-1:0]    cur_ff, cur_in;
   logic [7:0]             c_ff, c_in;
   logic [8:0]             km_ff, km_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Token produced this cycle.
   logic                   tok_v, tok_last;
   logic [4:0]             tok_kind;
   logic [2:0]             tok_err;
   logic [POS_BITS-1:0]    tok_s, tok_e;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr, ram_raddr;
   logic [COLUMN_BITS-1:0] ram_rdata;

   logic                   slot_free, acc, run_start;
   logic [7:0]             sc, c;
   logic [POS_BITS-1:0]    sp, p;
   start_type              st, st_idle_after, st_ded_after;

   iat_ram #(
      .WIDTH(COLUMN_BITS),
      .DEPTH(INDENT_DEPTH)
   ) u_stack (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(col_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign acc        = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign p          = pos_ff;

   // The token-start decode runs on the incoming byte when idle, on the held byte later.
   assign sc = (state_ff == S_START) ? c_ff : c;
   assign sp = (state_ff == S_START) ? cur_ff : pos_ff;
   assign st = start_decode(sc, als_ff);
   // Whether a token-start on this byte would emit once at_line_start has dropped.
   assign st_idle_after = start_decode(c, 1'b0);
   assign st_ded_after  = start_decode(c_ff, 1'b0);

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      als_in    = als_ff;
      halted_in = halted_ff;
      col_in    = col_ff;
      top_in    = top_ff;
      cnt_in    = cnt_ff;
      ded_in    = ded_ff;
      ts_in     = ts_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      c_in      = c_ff;
      km_in     = km_ff;
      tok_v     = 1'b0;
      tok_last  = 1'b1;
      tok_kind  = K_ERROR;
      tok_err   = E_NONE;
      tok_s     = ts_ff;
      tok_e     = p;
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[IDX_W-1:0];
      ram_raddr = IDX_W'(cnt_ff - CNT_W'(2));
      run_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               pos_in = pos_ff + POS_BITS'(1);
               c_in   = c;
               cur_in = p;
               if (!halted_ff) begin
                  case (mode_ff)
                     M_LINE: begin
                        if (c == CH_SPACE) begin
                           if (col_ff != '1) begin
                              col_in = col_ff + COLUMN_BITS'(1);
                           end
                        end else if (c == CH_HASH || c == CH_LF || col_ff == top_ff) begin
                           run_start = 1'b1;
                        end else if (col_ff > top_ff) begin
                           tok_v = 1'b1;
                           tok_s = p - POS_BITS'(col_ff) + POS_BITS'(top_ff);
                           tok_e = p;
                           if (cnt_ff >= CNT_W'(INDENT_DEPTH)) begin
                              tok_err = E_TOO_DEEP;
                           end else begin
                              ram_we   = 1'b1;
                              cnt_in   = cnt_ff + CNT_W'(1);
                              top_in   = col_ff;
                              tok_kind = K_INDENT;
                              tok_last = !st_idle_after.emit;
                              state_in = S_START;
                           end
                        end else begin
                           ded_in   = '0;
                           state_in = S_POP;
                        end
                     end
                     M_COMMENT: begin
                        if (c == CH_LF) begin
                           tok_v    = !als_ff;
                           tok_kind = K_NEWLINE;
                           tok_e    = p + POS_BITS'(1);
                           als_in   = 1'b1;
                           col_in   = '0;
                           mode_in  = M_LINE;
                        end else if (c == CH_NUL) begin
                           tok_v    = 1'b1;
                           tok_kind = K_EOF;
                           tok_s    = p;
                        end
                     end
                     M_INT: begin
                        if (!is_digit(c)) begin
                           tok_v    = 1'b1;
                           tok_kind = K_INT;
                           tok_last = !st_idle_after.emit;
                           state_in = S_START;
                        end
                     end
                     M_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                           km_in = kw_feed(km_ff, c);
                        end else begin
                           tok_v    = 1'b1;
                           tok_kind = kw_kind(km_ff);
                           tok_last = !st_idle_after.emit;
                           state_in = S_START;
                        end
                     end
                     M_STRING: begin
                        if (c == CH_QUOTE) begin
                           tok_v    = 1'b1;
                           tok_kind = K_STRING;
                           tok_e    = p + POS_BITS'(1);
                           mode_in  = M_NORMAL;
                        end else if (c == CH_LF || c == CH_NUL) begin
                           tok_v   = 1'b1;
                           tok_err = E_UNTERM;
                        end
                     end
                     M_OPEQ, M_OPBANG, M_OPLT, M_OPGT: begin
                        tok_v = 1'b1;
                        if (c == CH_EQ) begin
                           tok_e   = p + POS_BITS'(1);
                           mode_in = M_NORMAL;
                           case (mode_ff)
                              M_OPEQ:   tok_kind = K_EQ;
                              M_OPBANG: tok_kind = K_NE;
                              M_OPLT:   tok_kind = K_LE;
                              default:  tok_kind = K_GE;
                           endcase
                        end else begin
                           case (mode_ff)
                              M_OPEQ:   tok_kind = K_EQUALS;
                              M_OPBANG: tok_err  = E_SYNTAX;
                              M_OPLT:   tok_kind = K_LT;
                              default:  tok_kind = K_GT;
                           endcase
                           // A lone bang halts, so nothing follows it.
                           if (mode_ff != M_OPBANG) begin
                              tok_last = !st_idle_after.emit;
                              state_in = S_START;
                           end
                        end
                     end
                     default: run_start = 1'b1;
                  endcase
               end
            end
         end
         S_POP: begin
            if (cnt_ff > CNT_W'(1) && col_ff < top_ff) begin
               cnt_in = cnt_ff - CNT_W'(1);
               ded_in = ded_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(2)) begin
                  top_in = '0;
               end else begin
                  state_in = S_POPW;
               end
            end else if (col_ff != top_ff) begin
               if (slot_free) begin
                  tok_v    = 1'b1;
                  tok_err  = E_UNINDENT;
                  tok_s    = cur_ff - POS_BITS'(col_ff);
                  tok_e    = cur_ff;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_DED;
            end
         end
         S_POPW: begin
            top_in   = ram_rdata;
            state_in = S_POP;
         end
         S_DED: begin
            if (slot_free) begin
               tok_v    = 1'b1;
               tok_kind = K_DEDENT;
               tok_s    = cur_ff - POS_BITS'(col_ff);
               tok_e    = cur_ff;
               tok_last = (ded_ff == CNT_W'(1)) && !st_ded_after.emit;
               ded_in   = ded_ff - CNT_W'(1);
               if (ded_ff == CNT_W'(1)) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (slot_free || !st.emit) begin
               run_start = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // First byte of a new token.
      if (run_start) begin
         mode_in = st.mode;
         ts_in   = sp;
         if (st.mode == M_IDENT) begin
            km_in = kw_feed(KW_FRESH, sc);
         end
         if (st.nl) begin
            als_in = 1'b1;
            col_in = '0;
         end
         if (st.emit) begin
            tok_v    = 1'b1;
            tok_kind = st.kind;
            tok_err  = st.err;
            tok_s    = sp;
            tok_e    = st.wide ? sp + POS_BITS'(1) : sp;
            tok_last = 1'b1;
         end
      end

      // End of source and errors halt; any other non-newline token leaves line start.
      if (tok_v) begin
         if (tok_kind == K_EOF || tok_kind == K_ERROR) begin
            halted_in = 1'b1;
         end else if (tok_kind != K_NEWLINE) begin
            als_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (tok_v) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {tok_err, tok_e, tok_s, tok_kind};
         rsp_last_in  = tok_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_LINE;
         als_ff       <= 1'b1;
         halted_ff    <= 1'b0;
         col_ff       <= '0;
         top_ff       <= '0;
         cnt_ff       <= CNT_W'(1);
         ded_ff       <= '0;
         ts_ff        <= '0;
         pos_ff       <= '0;
         km_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         als_ff       <= als_in;
         halted_ff    <= halted_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         ded_ff       <= ded_in;
         ts_ff        <= ts_in;
         pos_ff       <= pos_in;
         km_ff        <= km_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= CNT_W'(INDENT_DEPTH))
      else $error("indentation stack count out of range");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted state cleared without reset");

   a_ded_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DED |-> ded_ff != '0)
      else $error("dedent run with no levels popped");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> cnt_ff < CNT_W'(INDENT_DEPTH) && col_ff > top_ff)
      else $error("indentation push without room or without deeper column");

endmodule
`default_nettype wire

[rtl/iat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iat_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire
